FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/s2i_pkg.sv
// Shared types, constants and helper functions for the string to integer parser.
// No dependencies; imported by every module of the block.
package s2i_pkg;

    localparam int ACC_W        = 64;
    localparam int BASE_W       = 6;
    localparam int DIGIT_W      = 6;
    localparam int PROD_W       = ACC_W + BASE_W;
    localparam int END_OFFSET_W = 12;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SELECT     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGNITUDE_LIMIT = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_B  = 8'h42;
    localparam logic [7:0] CHAR_UC_X  = 8'h58;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_B  = 8'h62;
    localparam logic [7:0] CHAR_LC_X  = 8'h78;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;

    localparam logic [BASE_W-1:0]  BASE_BIN  = 6'd2;
    localparam logic [BASE_W-1:0]  BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0]  BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0]  BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0]  BASE_MAX  = 6'd36;
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 6'd63;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [ACC_W-1:0]        value;
        logic                    overflow;
        logic [END_OFFSET_W-1:0] end_offset;
    } out_item_t;

    // Word passed from the front to the back through the queue
    typedef struct packed {
        logic               take;
        logic               digit_op;
        logic               set_neg;
        logic               neg_val;
        logic               last;
        logic [DIGIT_W-1:0] digit;
        logic [BASE_W-1:0]  base;
    } cmd_t;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_AFTER_ZERO,
        PH_ZEROS,
        PH_DIGITS,
        PH_STOPPED
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_CHECK,
        BK_EMIT
    } back_state_t;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = {2'b00, NOT_DIGIT};
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d = c - CHAR_UC_A + 8'd10;
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d = c - CHAR_LC_A + 8'd10;
        end
        return d[DIGIT_W-1:0];
    endfunction

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        return (b > BASE_MAX) ? BASE_MAX : b;
    endfunction

endpackage

FILE: rtl/core/s2i_front.sv
// Front end: takes one character per word, tracks the prefix phase and base,
// and issues commands to the back end. Depends on s2i_pkg.
module s2i_front import s2i_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BASE_W-1:0] base_select,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output cmd_t              push_cmd
);

    phase_t             phase_reg, phase_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    phase_t             eff_phase;
    logic [BASE_W-1:0]  eff_base;
    logic [BASE_W-1:0]  cfg_base;
    logic [DIGIT_W-1:0] digit;
    logic               digit_ok;
    logic               s_fire, end_str;
    logic               is_nul, is_space, is_sign, is_minus, is_zero;
    logic               is_bin, is_hex, is_oct;
    cmd_t               cmd;

    assign s_ready  = push_ready;
    assign s_fire   = s_valid && s_ready;

    assign is_nul   = (s_data.char_code == CHAR_NUL);
    assign is_space = (s_data.char_code == CHAR_SPACE);
    assign is_minus = (s_data.char_code == CHAR_MINUS);
    assign is_sign  = is_minus || (s_data.char_code == CHAR_PLUS);
    assign is_zero  = (s_data.char_code == CHAR_ZERO);
    assign is_bin   = (s_data.char_code == CHAR_LC_B) || (s_data.char_code == CHAR_UC_B);
    assign is_hex   = (s_data.char_code == CHAR_LC_X) || (s_data.char_code == CHAR_UC_X);
    assign is_oct   = (s_data.char_code >= CHAR_ZERO) && (s_data.char_code <= CHAR_SEVEN);
    assign end_str  = is_nul || s_data.last_char;
    assign cfg_base = clamp_base(base_select);

    // Resolve fall-through: the phase in which this character is finally handled
    always_comb begin
        eff_phase = phase_reg;
        eff_base  = base_reg;
        if (eff_phase == PH_SPACE && !is_space && !is_sign) begin
            eff_phase = PH_PREFIX;
        end
        if (eff_phase == PH_PREFIX && !is_zero) begin
            eff_base  = (base_select != '0) ? cfg_base : BASE_DEC;
            eff_phase = PH_ZEROS;
        end
        if (eff_phase == PH_AFTER_ZERO && !is_bin && !is_hex) begin
            if (base_select != '0) begin
                eff_base = cfg_base;
            end else begin
                eff_base = is_oct ? BASE_OCT : BASE_DEC;
            end
            eff_phase = PH_ZEROS;
        end
        if (eff_phase == PH_ZEROS && !is_zero) begin
            eff_phase = PH_DIGITS;
        end
    end

    assign digit    = digit_value(s_data.char_code);
    assign digit_ok = (digit < eff_base);

    // Next state
    always_comb begin
        phase_next = phase_reg;
        base_next  = base_reg;
        if (s_fire) begin
            if (!is_nul) begin
                base_next = eff_base;
                unique case (eff_phase)
                    PH_SPACE: begin
                        phase_next = is_sign ? PH_PREFIX : PH_SPACE;
                    end
                    PH_PREFIX: begin
                        phase_next = PH_AFTER_ZERO;
                    end
                    PH_AFTER_ZERO: begin
                        phase_next = PH_ZEROS;
                        if (base_select != '0) begin
                            base_next = cfg_base;
                        end else begin
                            base_next = is_bin ? BASE_BIN : BASE_HEX;
                        end
                    end
                    PH_ZEROS: begin
                        phase_next = PH_ZEROS;
                    end
                    PH_DIGITS: begin
                        phase_next = digit_ok ? PH_DIGITS : PH_STOPPED;
                    end
                    default: begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
            if (end_str) begin
                phase_next = PH_SPACE;
                base_next  = '0;
            end
        end
    end

    // Outputs
    always_comb begin
        cmd          = '0;
        cmd.last     = end_str;
        cmd.digit    = digit;
        cmd.base     = eff_base;
        cmd.neg_val  = is_minus;
        if (!is_nul) begin
            unique case (eff_phase)
                PH_SPACE: begin
                    cmd.take    = 1'b1;
                    cmd.set_neg = is_sign;
                end
                PH_PREFIX, PH_AFTER_ZERO, PH_ZEROS: begin
                    cmd.take = 1'b1;
                end
                PH_DIGITS: begin
                    cmd.digit_op = digit_ok;
                end
                default: begin
                    cmd.take = 1'b0;
                end
            endcase
        end
        push_cmd   = cmd;
        // drop words that change nothing downstream
        push_valid = s_fire && (cmd.take || cmd.digit_op || cmd.last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SPACE;
            base_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
        end
    end

endmodule

FILE: rtl/core/s2i_queue.sv
// Short command queue between front and back ends, register based.
// Depends on s2i_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s2i_queue import s2i_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              push, pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")

endmodule

FILE: rtl/core/s2i_back.sv
// Back end: applies commands, runs the multiply and limit check per digit,
// and registers one result per string. Depends on s2i_pkg and assert_macros.svh.
`include "assert_macros.svh"

module s2i_back import s2i_pkg::*; #(
    parameter int MAX_OFFSET = 4095
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [ACC_W-1:0] magnitude_limit,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  cmd_t             pop_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    localparam int CNT_W = $clog2(MAX_OFFSET + 1);

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   count_reg, count_next, count_inc;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    out_item_t          out_reg;
    logic               m_valid_reg;
    logic               out_load;
    logic [PROD_W:0]    sum;
    logic               over_limit;

    assign count_inc  = (count_reg < CNT_W'(MAX_OFFSET)) ? count_reg + 1'b1 : count_reg;
    assign sum        = {1'b0, prod_reg} + (PROD_W + 1)'(cmd_reg.digit);
    assign over_limit = (sum > (PROD_W + 1)'(magnitude_limit));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    if (pop_cmd.digit_op && !ovf_reg) begin
                        state_next = BK_MUL;
                    end else if (pop_cmd.last) begin
                        state_next = BK_EMIT;
                    end
                end
            end
            BK_MUL: begin
                state_next = BK_CHECK;
            end
            BK_CHECK: begin
                state_next = cmd_reg.last ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT: begin
                if (out_load) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        pop_ready  = (state_reg == BK_IDLE);
        out_load   = (state_reg == BK_EMIT) && (!m_valid_reg || m_ready);
        acc_next   = acc_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    if (pop_cmd.set_neg) begin
                        neg_next = pop_cmd.neg_val;
                    end
                    if (pop_cmd.take) begin
                        count_next = count_inc;
                    end
                end
            end
            BK_CHECK: begin
                // an overflowing digit is not consumed and stops the string
                if (over_limit) begin
                    ovf_next = 1'b1;
                end else begin
                    acc_next   = sum[ACC_W-1:0];
                    count_next = count_inc;
                end
            end
            BK_EMIT: begin
                if (out_load) begin
                    acc_next   = '0;
                    count_next = '0;
                    neg_next   = 1'b0;
                    ovf_next   = 1'b0;
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            cmd_reg <= pop_cmd;
        end
        if (state_reg == BK_MUL) begin
            prod_reg <= PROD_W'(acc_reg) * PROD_W'(cmd_reg.base);
        end
        if (out_load) begin
            out_reg.overflow   <= ovf_reg;
            out_reg.end_offset <= END_OFFSET_W'(count_reg);
            if (ovf_reg) begin
                out_reg.value <= '0;
            end else if (neg_reg) begin
                out_reg.value <= '0 - acc_reg;
            end else begin
                out_reg.value <= acc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            acc_reg     <= '0;
            count_reg   <= '0;
            neg_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ASSERT_IMPLY(a_ovf_zero, m_valid_reg && out_reg.overflow, out_reg.value == '0, "overflow result not zero")
    `ASSERT_NEXT(a_mul_check, state_reg == BK_MUL, state_reg == BK_CHECK, "multiply not followed by check")
    `ASSERT_ALWAYS(a_count_sat, count_reg <= CNT_W'(MAX_OFFSET), "consumed count past saturation")

endmodule

FILE: rtl/core/string_to_integer_parser_top.sv
// Top level of the string to integer parser: configuration registers and the
// front, queue and back instances. Depends on s2i_pkg, s2i_front, s2i_queue, s2i_back.
//
//   port group   direction  handshake         payload
//   s_*          in         s_valid/s_ready   in_item_t  (char_code, last_char)
//   m_*          out        m_valid/m_ready   out_item_t (value, overflow, end_offset)
//   cfg_*        in         cfg_we            cfg_index, cfg_wdata
//
// The front takes one character word per cycle while the queue has room.
// For a digit the back steps through its pop, 64x6 multiply, and add and limit
// compare states; other characters need only the pop, and a result adds an emit
// state. The back pops a new command only from idle, so its multiply-compare
// sequence sets the sustained rate. Synchronous active-low reset clears all parse
// state and sets base_select to 0 and magnitude_limit to all ones.
// A four-word queue and the output register let the front keep accepting
// while m_ready is held low, until the queue fills.
module string_to_integer_parser_top import s2i_pkg::*; #(
    parameter int MAX_OFFSET = 4095
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ACC_W-1:0]       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data
);

    logic [BASE_W-1:0] base_select_reg;
    logic [ACC_W-1:0]  magnitude_limit_reg;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    cmd_t              push_cmd, pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_select_reg     <= '0;
            magnitude_limit_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_SELECT: begin
                    base_select_reg <= cfg_wdata[BASE_W-1:0];
                end
                CFG_MAGNITUDE_LIMIT: begin
                    magnitude_limit_reg <= cfg_wdata;
                end
                default: begin
                    base_select_reg <= base_select_reg;
                end
            endcase
        end
    end

    s2i_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .base_select (base_select_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    s2i_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    s2i_back #(
        .MAX_OFFSET (MAX_OFFSET)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .magnitude_limit (magnitude_limit_reg),
        .pop_valid       (pop_valid),
        .pop_ready       (pop_ready),
        .pop_cmd         (pop_cmd),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

endmodule

FILE: test/string_to_integer_parser_top_tb.sv
// Self-checking testbench for string_to_integer_parser_top: directed strings, then random
// strings under several base and limit settings, checked against an in-bench parser model.
// Depends on s2i_pkg and the parser RTL only.
`timescale 1ns / 100ps

module string_to_integer_parser_top_tb;
    import s2i_pkg::*;

    localparam int OFFSET_CAP      = 4095;
    localparam int TEXT_BYTES      = 24;
    localparam int DIR_ROWS        = 24;
    localparam int RANDOM_PHASES   = 11;
    localparam int PHASE_ITEMS     = 140;
    localparam int HOLD_PHASE      = 3;
    localparam int SPACE_RUN_PHASE = 5;
    localparam int SPACE_RUN_LEN   = 40;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_TAIL      = 16;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [BASE_W-1:0]         base;
        logic [63:0]               limit;
        logic [8*TEXT_BYTES-1:0]   text;
        logic                      end_nul;
        logic                      typed;
        logic [63:0]               val;
        logic                      ovf;
        logic [END_OFFSET_W-1:0]   off;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ACC_W-1:0]       cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;

    string_to_integer_parser_top #(
        .MAX_OFFSET(OFFSET_CAP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Parser model: register copies and per-string state
    logic [BASE_W-1:0]       cfg_base;
    logic [63:0]             cfg_limit;
    phase_t                  parse_phase;
    logic                    parse_neg;
    logic [BASE_W-1:0]       parse_base;
    logic [63:0]             parse_acc;
    logic                    parse_ovf;
    logic                    parse_stopped;
    logic [END_OFFSET_W-1:0] parse_count;

    out_item_t pending_results[$];
    in_item_t  string_words[$];
    dir_row_t  dir_rows[DIR_ROWS];
    out_item_t typed_result;
    logic      typed_pending = 1'b0;

    int  error_count    = 0;
    int  results_seen   = 0;
    int  strings_sent   = 0;
    int  chars_sent     = 0;
    int  configs_done   = 0;
    int  cycle_count    = 0;
    int  gap_odds       = 6;
    int  stall_odds     = 7;
    logic calm          = 1'b0;
    logic hold_request  = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_parse();
        parse_phase   = PH_SPACE;
        parse_neg     = 1'b0;
        parse_base    = '0;
        parse_acc     = '0;
        parse_ovf     = 1'b0;
        parse_stopped = 1'b0;
        parse_count   = '0;
    endfunction

    function automatic logic [BASE_W-1:0] effective_base();
        return (cfg_base > BASE_MAX) ? BASE_MAX : cfg_base;
    endfunction

    function automatic logic [5:0] char_digit(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return 6'(c - CHAR_ZERO);
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) return 6'(c - CHAR_UC_A + 8'd10);
        if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return 6'(c - CHAR_LC_A + 8'd10);
        return NOT_DIGIT;
    endfunction

    function automatic void count_char();
        if (parse_count < OFFSET_CAP) parse_count = parse_count + 1'b1;
    endfunction

    function automatic void halt_parse();
        parse_phase   = PH_STOPPED;
        parse_stopped = 1'b1;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] b;
        logic        done;
        done = 1'b0;
        while (!done) begin
            done = 1'b1;
            case (parse_phase)
                PH_SPACE: begin
                    if (c == CHAR_SPACE) begin
                        count_char();
                    end else begin
                        parse_phase = PH_PREFIX;
                        if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                            parse_neg = (c == CHAR_MINUS);
                            count_char();
                        end else begin
                            done = 1'b0;
                        end
                    end
                end
                PH_PREFIX: begin
                    if (c == CHAR_ZERO) begin
                        count_char();
                        parse_phase = PH_AFTER_ZERO;
                    end else begin
                        parse_base  = (cfg_base != 0) ? effective_base() : BASE_DEC;
                        parse_phase = PH_ZEROS;
                        done = 1'b0;
                    end
                end
                PH_AFTER_ZERO: begin
                    parse_phase = PH_ZEROS;
                    if (c == CHAR_LC_B || c == CHAR_UC_B) begin
                        parse_base = (cfg_base != 0) ? effective_base() : BASE_BIN;
                        count_char();
                    end else if (c == CHAR_LC_X || c == CHAR_UC_X) begin
                        parse_base = (cfg_base != 0) ? effective_base() : BASE_HEX;
                        count_char();
                    end else begin
                        if (cfg_base != 0)
                            parse_base = effective_base();
                        else
                            parse_base = (c >= CHAR_ZERO && c <= CHAR_SEVEN) ? BASE_OCT : BASE_DEC;
                        done = 1'b0;
                    end
                end
                PH_ZEROS: begin
                    if (c == CHAR_ZERO) begin
                        count_char();
                    end else begin
                        parse_phase = PH_DIGITS;
                        done = 1'b0;
                    end
                end
                PH_DIGITS: begin
                    d = 64'(char_digit(c));
                    b = (parse_base != 0) ? 64'(parse_base) : 64'(BASE_DEC);
                    if (d >= b) begin
                        halt_parse();
                    end else if (d > cfg_limit || parse_acc > (cfg_limit - d) / b) begin
                        parse_ovf = 1'b1;
                        halt_parse();
                    end else begin
                        parse_acc = parse_acc * b + d;
                        count_char();
                    end
                end
                default: halt_parse();
            endcase
        end
    endfunction

    // Advance the model by one word; returns 1 when the word closes a string
    function automatic logic step_parser(input logic [7:0] c, input logic l,
                                         output out_item_t r);
        r = '0;
        if (c != CHAR_NUL && !parse_stopped) parse_char(c);
        if (c != CHAR_NUL && !l) return 1'b0;
        r.value      = parse_ovf ? 64'd0 : (parse_neg ? (64'd0 - parse_acc) : parse_acc);
        r.overflow   = parse_ovf;
        r.end_offset = parse_count;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic in_item_t word_of(input logic [7:0] c, input logic l);
        in_item_t w;
        w.char_code = c;
        w.last_char = l;
        return w;
    endfunction

    function automatic dir_row_t mk_row(input logic [BASE_W-1:0] base, input logic [63:0] limit,
                                        input logic [8*TEXT_BYTES-1:0] text, input logic end_nul,
                                        input logic typed, input logic [63:0] val,
                                        input logic ovf, input logic [END_OFFSET_W-1:0] off);
        dir_row_t r;
        r.base = base; r.limit = limit; r.text = text; r.end_nul = end_nul;
        r.typed = typed; r.val = val; r.ovf = ovf; r.off = off;
        return r;
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'(CHAR_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CHAR_UC_A : CHAR_LC_A) + d - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: return CHAR_SPACE;
            1: return CHAR_PLUS;
            2: return CHAR_MINUS;
            3: return CHAR_ZERO;
            4: return CHAR_LC_X;
            5: return CHAR_UC_B;
            6: return CHAR_SEVEN;
            7: return CHAR_NINE;
            8: return CHAR_LC_Z;
            default: return CHAR_UC_Z;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
        error_count++;
    endtask

    task automatic sender_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic send_word(input in_item_t w);
        out_item_t r;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            sender_gap($urandom_range(1, 18));
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (step_parser(w.char_code, w.last_char, r)) begin
            pending_results.push_back(typed_pending ? typed_result : r);
            typed_pending = 1'b0;
            strings_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
    endtask

    // Write both registers while the block is idle; junk above the base field
    task automatic write_config(input logic [BASE_W-1:0] base, input logic [63:0] limit);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_SELECT;
        cfg_wdata <= {junk[63:BASE_W], base};
        @(posedge aclk);
        cfg_index <= CFG_MAGNITUDE_LIMIT;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cfg_base  = base;
        cfg_limit = limit;
        configs_done++;
    endtask

    // Mostly well-formed numbers with random content; the rest noise or corrupted
    task automatic compose_string();
        int kind;
        int pre;
        int dbase;
        int ndig;
        int pos;
        string_words.delete();
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            ndig = $urandom_range(1, 12);
            for (int k = 0; k < ndig; k++)
                string_words.push_back(word_of(noise_char(), $urandom_range(0, 7) == 0));
        end else begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4)) string_words.push_back(word_of(CHAR_SPACE, 1'b0));
            case ($urandom_range(0, 2))
                1: string_words.push_back(word_of(CHAR_PLUS, 1'b0));
                2: string_words.push_back(word_of(CHAR_MINUS, 1'b0));
                default: ;
            endcase
            pre = $urandom_range(0, 4);
            if (pre >= 1 && pre <= 3) string_words.push_back(word_of(CHAR_ZERO, 1'b0));
            if (pre == 1)
                string_words.push_back(word_of($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X, 1'b0));
            if (pre == 2)
                string_words.push_back(word_of($urandom_range(0, 1) ? CHAR_LC_B : CHAR_UC_B, 1'b0));
            if (cfg_base != 0)
                dbase = int'(effective_base());
            else
                dbase = (pre == 1) ? 16 : (pre == 2) ? 2 : (pre == 3) ? 8 : 10;
            repeat ($urandom_range(0, 2)) string_words.push_back(word_of(CHAR_ZERO, 1'b0));
            ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            repeat (ndig)
                string_words.push_back(word_of(digit_char($urandom_range(0, dbase - 1)), 1'b0));
            if (kind == 9) begin
                pos = $urandom_range(0, string_words.size() - 1);
                string_words[pos].char_code = 8'($urandom_range(1, 255));
            end
        end
        case ($urandom_range(0, 3))
            0: string_words[string_words.size() - 1].last_char = 1'b1;
            1: string_words.push_back(word_of(CHAR_NUL, $urandom_range(0, 1)));
            2: string_words.push_back(word_of(8'($urandom_range(1, 255)), 1'b1));
            default: begin
                string_words.push_back(word_of(8'($urandom_range(1, 255)), 1'b0));
                string_words.push_back(word_of(CHAR_NUL, $urandom_range(0, 1)));
            end
        endcase
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_data.value, 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.value !== want.value)
                    report_mismatch("value", m_data.value, want.value);
                if (m_data.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(m_data.overflow), 64'(want.overflow));
                if (m_data.end_offset !== want.end_offset)
                    report_mismatch("end_offset", 64'(m_data.end_offset), 64'(want.end_offset));
            end
            results_seen++;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
                hold_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("string_to_integer_parser_top regression: fail");
            $finish;
        end
    end

    initial begin
        dir_row_t    row;
        logic [7:0]  ch;
        logic [BASE_W-1:0] base_v;
        logic [63:0] limit_v;
        int          phase_count;

        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_BASE_SELECT;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_base  = '0;
        cfg_limit = ALL_ONES;
        clear_parse();

        dir_rows[0]  = mk_row(0, ALL_ONES, "", 1, 1, 64'd0, 0, 0);
        dir_rows[1]  = mk_row(0, ALL_ONES, "   42", 0, 1, 64'd42, 0, 5);
        dir_rows[2]  = mk_row(0, ALL_ONES, "-1", 1, 1, ALL_ONES, 0, 2);
        dir_rows[3]  = mk_row(0, ALL_ONES, "+0x1F", 0, 0, 0, 0, 0);
        dir_rows[4]  = mk_row(0, ALL_ONES, " -0B101", 1, 0, 0, 0, 0);
        dir_rows[5]  = mk_row(0, ALL_ONES, "0178", 0, 0, 0, 0, 0);
        dir_rows[6]  = mk_row(0, ALL_ONES, "0x", 1, 1, 64'd0, 0, 2);
        dir_rows[7]  = mk_row(0, ALL_ONES, "09z", 0, 0, 0, 0, 0);
        dir_rows[8]  = mk_row(0, ALL_ONES, "18446744073709551615", 0, 1, ALL_ONES, 0, 20);
        dir_rows[9]  = mk_row(0, ALL_ONES, "18446744073709551616", 1, 1, 64'd0, 1, 19);
        dir_rows[10] = mk_row(0, ALL_ONES, "\t7", 0, 0, 0, 0, 0);
        dir_rows[11] = mk_row(0, ALL_ONES, "00042 9", 1, 0, 0, 0, 0);
        dir_rows[12] = mk_row(16, ALL_ONES, "0xfF", 0, 0, 0, 0, 0);
        dir_rows[13] = mk_row(16, ALL_ONES, "0bAg", 1, 0, 0, 0, 0);
        dir_rows[14] = mk_row(36, ALL_ONES, "zZ+", 0, 0, 0, 0, 0);
        dir_rows[15] = mk_row(63, ALL_ONES, "Zz", 1, 0, 0, 0, 0);
        dir_rows[16] = mk_row(1, ALL_ONES, "0001", 0, 0, 0, 0, 0);
        dir_rows[17] = mk_row(2, 64'd5, "110", 1, 0, 0, 0, 0);
        dir_rows[18] = mk_row(0, 64'd0, "5", 0, 1, 64'd0, 1, 0);
        dir_rows[19] = mk_row(0, 64'd0, "-0", 1, 0, 0, 0, 0);
        dir_rows[20] = mk_row(8, ALL_ONES, "0X7", 0, 0, 0, 0, 0);
        dir_rows[21] = mk_row(10, 64'hFFFF_FFFF, "4294967296", 0, 0, 0, 0, 0);
        dir_rows[22] = mk_row(0, ALL_ONES, " +", 0, 0, 0, 0, 0);
        dir_rows[23] = mk_row(0, ALL_ONES, "-9223372036854775808", 1, 0, 0, 0, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.base != cfg_base || row.limit != cfg_limit)
                write_config(row.base, row.limit);
            string_words.delete();
            for (int k = TEXT_BYTES - 1; k >= 0; k--) begin
                ch = row.text[8*k +: 8];
                if (ch != CHAR_NUL) string_words.push_back(word_of(ch, 1'b0));
            end
            if (row.end_nul)
                string_words.push_back(word_of(CHAR_NUL, $urandom_range(0, 1)));
            else
                string_words[string_words.size() - 1].last_char = 1'b1;
            typed_pending = row.typed;
            typed_result.value      = row.val;
            typed_result.overflow   = row.ovf;
            typed_result.end_offset = row.off;
            foreach (string_words[k]) send_word(string_words[k]);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin base_v = 0; limit_v = ALL_ONES; end
                1: begin base_v = BASE_DEC; limit_v = {$urandom, $urandom}; end
                2: begin base_v = BASE_HEX; limit_v = ALL_ONES; end
                3: begin base_v = 0; limit_v = ALL_ONES; end
                4: begin base_v = BASE_BIN; limit_v = 64'($urandom_range(0, 1000)); end
                5: begin base_v = BASE_MAX; limit_v = {$urandom, $urandom}; end
                6: begin base_v = BASE_OCT; limit_v = ALL_ONES; end
                7: begin base_v = 1; limit_v = ALL_ONES; end
                8: begin
                    base_v  = 6'($urandom_range(37, 63));
                    limit_v = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                9: begin
                    base_v  = 6'($urandom_range(0, 36));
                    limit_v = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
                default: begin base_v = 0; limit_v = ALL_ONES; end
            endcase
            write_config(base_v, limit_v);
            gap_odds   = (p % 3 == 1) ? 0 : 6;
            stall_odds = (p % 4 == 2) ? 0 : 7;
            if (p == RANDOM_PHASES - 1) begin
                calm       = 1'b1;
                gap_odds   = 0;
                stall_odds = 0;
            end
            // hold the output while words keep coming, so the input stalls
            if (p == HOLD_PHASE) hold_request = 1'b1;
            // long run of leading spaces before a single digit
            if (p == SPACE_RUN_PHASE) begin
                repeat (SPACE_RUN_LEN) send_word(word_of(CHAR_SPACE, 1'b0));
                send_word(word_of(CHAR_SEVEN, 1'b1));
            end
            phase_count = 0;
            while (phase_count < PHASE_ITEMS) begin
                compose_string();
                foreach (string_words[k]) send_word(string_words[k]);
                phase_count += string_words.size();
            end
        end

        wait_drained();
        $display("Covered %0d strings in %0d characters over %0d register settings",
                 strings_sent, chars_sent, configs_done);
        $display("Included bases 0 to 63, zero and full limits, long space runs and %0d-cycle hold",
                 LONG_HOLD);
        if (error_count == 0) begin
            $display("string_to_integer_parser_top regression: pass");
        end else begin
            $display("string_to_integer_parser_top regression: fail");
        end
        $finish;
    end

endmodule
